// ===== hw/rtl/vsrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vsrt_pkg
// Shared types and constants of the video scroll register and timing core.
// ----------------------------------------------------------------------------
package vsrt_pkg;

  localparam int OAM_BYTES = 256;
  localparam int OAM_AW    = $clog2(OAM_BYTES);
  localparam int CNT_W     = 9;
  localparam int ADDR_W    = 15;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_idx_t;

  localparam logic [CNT_W-1:0] LINE_VISIBLE_LAST = 9'd239;
  localparam logic [CNT_W-1:0] LINE_VBLANK       = 9'd241;
  localparam logic [CNT_W-1:0] DOT_FLAG          = 9'd1;
  localparam logic [CNT_W-1:0] DOT_OAM_CLR_LAST  = 9'd64;
  localparam logic [CNT_W-1:0] DOT_Y_INC         = 9'd256;
  localparam logic [CNT_W-1:0] DOT_HCOPY         = 9'd257;
  localparam logic [CNT_W-1:0] DOT_VCOPY_FIRST   = 9'd280;
  localparam logic [CNT_W-1:0] DOT_VCOPY_LAST    = 9'd304;
  localparam logic [CNT_W-1:0] DOT_FETCH_FIRST   = 9'd321;
  localparam logic [CNT_W-1:0] DOT_FETCH_LAST    = 9'd336;
  localparam logic [4:0]       COARSE_Y_WRAP     = 5'd29;
  localparam logic [7:0]       OAM_CLEAR_BYTE    = 8'hFF;

  // One result transaction before the OAM read data is merged in.
  typedef struct packed {
    logic [7:0]        rdata;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [13:0]       vram_addr;
    logic              nmi;
    logic [CNT_W-1:0]  dot;
    logic [CNT_W-1:0]  line;
    logic [2:0]        fine_x;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [OAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } oam_req_t;

endpackage

// ===== hw/rtl/vsrt_ram.sv =====
// ----------------------------------------------------------------------------
// vsrt_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module vsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vsrt_regs.sv =====
// ----------------------------------------------------------------------------
// vsrt_regs
// Dot and line timing, the CPU-visible registers and the scroll latches.
// ----------------------------------------------------------------------------
module vsrt_regs #(
  parameter int DOTS_PER_LINE   = 341,
  parameter int LINES_PER_FRAME = 262
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        in_cmd,
  input  logic [2:0]        in_reg_index,
  input  logic [7:0]        in_wdata,
  input  logic [7:0]        in_mem_data,
  output vsrt_pkg::res_t     res,
  output logic              oam_rd,
  output vsrt_pkg::oam_req_t oam_req
);
  import vsrt_pkg::*;

  localparam logic [CNT_W-1:0] DOT_LAST  = CNT_W'(DOTS_PER_LINE - 1);
  localparam logic [CNT_W-1:0] LINE_LAST = CNT_W'(LINES_PER_FRAME - 1);

  logic [CNT_W-1:0]  dot_r, dot_nxt;
  logic [CNT_W-1:0]  line_r, line_nxt;
  logic              odd_r, odd_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic              vblank_r, vblank_nxt;
  logic              nmi_r, nmi_nxt;
  logic [ADDR_W-1:0] v_r, v_nxt;
  logic [ADDR_W-1:0] t_r, t_nxt;
  logic [2:0]        fx_r, fx_nxt;
  logic              wt_r, wt_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic [OAM_AW-1:0] oamp_r, oamp_nxt;

  logic              render_on;
  logic [ADDR_W-1:0] addr_inc;
  cmd_t              cmd;
  reg_idx_t          ridx;

  function automatic logic [ADDR_W-1:0] coarse_x_step(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    if (v[4:0] == 5'h1F) begin
      r = {v[14:11], ~v[10], v[9:5], 5'd0};
    end else begin
      r = v + ADDR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] y_step(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    logic [4:0]        cy;
    logic              nt;
    cy = v[9:5];
    nt = v[11];
    if (v[14:12] != 3'd7) begin
      r = {v[14:12] + 3'd1, v[11:0]};
    end else begin
      if (cy == COARSE_Y_WRAP) begin
        cy = 5'd0;
        nt = ~nt;
      end else if (cy == 5'h1F) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r = {3'd0, nt, v[10], cy, v[4:0]};
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] render_step(input logic [ADDR_W-1:0] v,
                                                     input logic [ADDR_W-1:0] t,
                                                     input logic [CNT_W-1:0]  d,
                                                     input logic              pre);
    logic [ADDR_W-1:0] r;
    r = v;
    if (d != '0) begin
      if ((d <= DOT_Y_INC) || (d >= DOT_FETCH_FIRST && d <= DOT_FETCH_LAST)) begin
        if (d[2:0] == 3'd0) begin
          r = coarse_x_step(r);
        end
        if (d == DOT_Y_INC) begin
          r = y_step(r);
        end
      end
      if (d == DOT_HCOPY) begin
        r = {r[14:11], t[10], r[9:5], t[4:0]};
      end
      if (pre && d >= DOT_VCOPY_FIRST && d <= DOT_VCOPY_LAST) begin
        r = {t[14:11], r[10], t[9:5], r[4:0]};
      end
    end
    return r;
  endfunction

  assign render_on = mask_r[4] | mask_r[3];
  assign addr_inc  = ctrl_r[2] ? ADDR_W'(32) : ADDR_W'(1);
  assign cmd       = cmd_t'(in_cmd);
  assign ridx      = reg_idx_t'(in_reg_index);

  always_comb begin
    dot_nxt    = dot_r;
    line_nxt   = line_r;
    odd_nxt    = odd_r;
    ctrl_nxt   = ctrl_r;
    mask_nxt   = mask_r;
    vblank_nxt = vblank_r;
    nmi_nxt    = nmi_r;
    v_nxt      = v_r;
    t_nxt      = t_r;
    fx_nxt     = fx_r;
    wt_nxt     = wt_r;
    rbuf_nxt   = rbuf_r;
    oamp_nxt   = oamp_r;

    res.rdata     = '0;
    res.mem_we    = 1'b0;
    res.mem_wdata = '0;
    oam_rd        = 1'b0;
    oam_req.we    = 1'b0;
    oam_req.re    = 1'b0;
    oam_req.addr  = oamp_r;
    oam_req.wdata = in_wdata;

    unique case (cmd)
      CMD_TICK: begin
        if (line_r <= LINE_VISIBLE_LAST) begin
          if (render_on) begin
            v_nxt = render_step(v_r, t_r, dot_r, 1'b0);
          end
        end else if (line_r == LINE_VBLANK && dot_r == DOT_FLAG) begin
          vblank_nxt = 1'b1;
          nmi_nxt    = ctrl_r[7];
        end else if (line_r == LINE_LAST) begin
          if (dot_r == DOT_FLAG) begin
            vblank_nxt = 1'b0;
          end
          if (render_on) begin
            v_nxt = render_step(v_r, t_r, dot_r, 1'b1);
          end
        end

        // On odd frames the first dot of the new frame is skipped.
        if (dot_r == DOT_LAST) begin
          dot_nxt = '0;
          if (line_r == LINE_LAST) begin
            line_nxt = '0;
            dot_nxt  = odd_r ? DOT_FLAG : '0;
            odd_nxt  = ~odd_r;
          end else begin
            line_nxt = line_r + CNT_W'(1);
          end
        end else begin
          dot_nxt = dot_r + CNT_W'(1);
        end
      end
      CMD_READ: begin
        case (ridx)
          REG_STATUS: begin
            res.rdata  = {vblank_r, 7'd0};
            vblank_nxt = 1'b0;
            wt_nxt     = 1'b0;
          end
          REG_OAM_DATA: begin
            if (line_r <= LINE_VISIBLE_LAST && dot_r >= DOT_FLAG &&
                dot_r <= DOT_OAM_CLR_LAST && render_on) begin
              res.rdata = OAM_CLEAR_BYTE;
            end else begin
              oam_rd     = 1'b1;
              oam_req.re = accept;
            end
          end
          REG_DATA: begin
            res.rdata = rbuf_r;
            rbuf_nxt  = in_mem_data;
            v_nxt     = v_r + addr_inc;
          end
          default: begin
          end
        endcase
      end
      CMD_WRITE: begin
        case (ridx)
          REG_CTRL: begin
            ctrl_nxt = in_wdata;
            t_nxt    = {t_r[14:12], in_wdata[1:0], t_r[9:0]};
          end
          REG_MASK: begin
            mask_nxt = in_wdata;
          end
          REG_OAM_ADDR: begin
            oamp_nxt = in_wdata;
          end
          REG_OAM_DATA: begin
            oam_req.we = accept;
            oamp_nxt   = oamp_r + OAM_AW'(1);
          end
          REG_SCROLL: begin
            if (!wt_r) begin
              t_nxt  = {t_r[14:5], in_wdata[7:3]};
              fx_nxt = in_wdata[2:0];
              wt_nxt = 1'b1;
            end else begin
              t_nxt  = {in_wdata[2:0], t_r[11:10], in_wdata[7:3], t_r[4:0]};
              wt_nxt = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!wt_r) begin
              t_nxt  = {1'b0, in_wdata[5:0], t_r[7:0]};
              wt_nxt = 1'b1;
            end else begin
              t_nxt  = {t_r[14:8], in_wdata};
              v_nxt  = {t_r[14:8], in_wdata};
              wt_nxt = 1'b0;
            end
          end
          REG_DATA: begin
            res.mem_we    = 1'b1;
            res.mem_wdata = in_wdata;
            v_nxt         = v_r + addr_inc;
          end
          default: begin
          end
        endcase
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase

    res.vram_addr = v_r[13:0];
    res.dot       = dot_r;
    res.line      = line_r;
    res.nmi       = nmi_nxt;
    res.fine_x    = fx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r    <= '0;
      line_r   <= '0;
      odd_r    <= 1'b0;
      ctrl_r   <= '0;
      mask_r   <= '0;
      vblank_r <= 1'b0;
      nmi_r    <= 1'b0;
      v_r      <= '0;
      t_r      <= '0;
      fx_r     <= '0;
      wt_r     <= 1'b0;
      rbuf_r   <= '0;
      oamp_r   <= '0;
    end else if (accept) begin
      dot_r    <= dot_nxt;
      line_r   <= line_nxt;
      odd_r    <= odd_nxt;
      ctrl_r   <= ctrl_nxt;
      mask_r   <= mask_nxt;
      vblank_r <= vblank_nxt;
      nmi_r    <= nmi_nxt;
      v_r      <= v_nxt;
      t_r      <= t_nxt;
      fx_r     <= fx_nxt;
      wt_r     <= wt_nxt;
      rbuf_r   <= rbuf_nxt;
      oamp_r   <= oamp_nxt;
    end
  end

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r <= DOT_LAST)
    else $error("dot counter out of range");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= LINE_LAST)
    else $error("line counter out of range");

  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_READ && ridx == REG_STATUS |=> !vblank_r && !wt_r)
    else $error("status read did not clear vblank and write toggle");

  a_oam_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(oam_req.we && oam_req.re))
    else $error("OAM read and write in the same transaction");

endmodule

// ===== hw/rtl/vsrt_out.sv =====
// ----------------------------------------------------------------------------
// vsrt_out
// Result pipeline: a stage that waits for OAM read data, then an output register.
// ----------------------------------------------------------------------------
module vsrt_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  vsrt_pkg::res_t res,
  input  logic          oam_rd,
  input  logic [7:0]    ram_q,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output vsrt_pkg::res_t out_res
);
  import vsrt_pkg::*;

  res_t s1_r;
  logic s1_oam_r;
  logic s1_v_r, s1_v_nxt;
  res_t out_r;
  logic out_v_r, out_v_nxt;
  logic s1_go;
  res_t s1_merged;

  // The RAM output only changes on an accepted transaction, so it stays matched
  // to the transaction held in the first stage.
  always_comb begin
    s1_merged = s1_r;
    if (s1_oam_r) begin
      s1_merged.rdata = ram_q;
    end
  end

  assign s1_go     = s1_v_r && (!out_v_r || !out_stall);
  assign busy      = s1_v_r && !s1_go;
  assign s1_v_nxt  = accept || (s1_v_r && !s1_go);
  assign out_v_nxt = s1_go || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r     <= res;
      s1_oam_r <= oam_rd;
    end
    if (s1_go) begin
      out_r <= s1_merged;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept)
    else $error("transaction accepted while first stage is blocked");

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> s1_v_r && out_v_r)
    else $error("blocked result was lost");

  a_we_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.mem_we |-> out_r.rdata == 8'd0)
    else $error("memory write carries read data");

endmodule

// ===== hw/rtl/video_scroll_register_timing_core.sv =====
// ----------------------------------------------------------------------------
// video_scroll_register_timing_core
// Pipeline: an accepted transaction is registered in the first stage and then in
// the output register, which drives out_valid and the result ports.
// Throughput: one transaction per cycle unless in_stall; at most one OAM access each.
// A result waiting on a stalled output still lets one more transaction in.
// Reset is synchronous and clears all timing and register state; OAM holds no reset.
// ----------------------------------------------------------------------------
module video_scroll_register_timing_core #(
  parameter int DOTS_PER_LINE   = 341,
  parameter int LINES_PER_FRAME = 262
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic        out_mem_we,
  output logic [7:0]  out_mem_wdata,
  output logic [13:0] out_vram_addr,
  output logic        out_nmi_out,
  output logic [8:0]  out_dot_pos,
  output logic [8:0]  out_line_pos,
  output logic [2:0]  out_fine_scroll_x
);
  import vsrt_pkg::*;

  logic     accept;
  logic     busy;
  res_t     res;
  res_t     out_res;
  logic     oam_rd;
  oam_req_t oam_req;
  logic [7:0] ram_q;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  vsrt_regs #(
    .DOTS_PER_LINE   (DOTS_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_cmd       (in_cmd),
    .in_reg_index (in_reg_index),
    .in_wdata     (in_wdata),
    .in_mem_data  (in_mem_data),
    .res          (res),
    .oam_rd       (oam_rd),
    .oam_req      (oam_req)
  );

  vsrt_ram #(
    .WIDTH (8),
    .DEPTH (OAM_BYTES)
  ) u_oam (
    .clk   (clk),
    .we    (oam_req.we),
    .waddr (oam_req.addr),
    .wdata (oam_req.wdata),
    .re    (oam_req.re),
    .raddr (oam_req.addr),
    .rdata (ram_q)
  );

  vsrt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .res       (res),
    .oam_rd    (oam_rd),
    .ram_q     (ram_q),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_rdata         = out_res.rdata;
  assign out_mem_we        = out_res.mem_we;
  assign out_mem_wdata     = out_res.mem_wdata;
  assign out_vram_addr     = out_res.vram_addr;
  assign out_nmi_out       = out_res.nmi;
  assign out_dot_pos       = out_res.dot;
  assign out_line_pos      = out_res.line;
  assign out_fine_scroll_x = out_res.fine_x;

endmodule
